[rtl/core/onb_pkg.sv]
// Shared constants and helpers for the Oren-Nayar reflectance evaluator.
`default_nettype none
package onb_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int FIELD_W          = 16;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 16;
    localparam int IN_W             = 6 * FIELD_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_A  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_B  = 4'd1;
    localparam int                   REG_ALBEDO_0 = 2;

    localparam logic [15:0] COEFF_A_RST = 16'd32768;
    localparam logic [15:0] COEFF_B_RST = 16'd0;
    localparam logic [15:0] ALBEDO_RST  = 16'hFFFF;

    // quotient bits kept by the divider; larger quotients saturate the result
    localparam int DIV_STEPS = 35;
    localparam int NUMER_W   = 48;
    localparam int W_W       = DIV_STEPS + 1;
    localparam int WM_W      = W_W + 15;

    localparam logic [14:0] INV_PI_Q16    = 15'd20861;
    localparam logic [31:0] INV_PI_Q32_X2 = 32'd2734261102;

    // |z| / pi in Q0.16, rounded
    function automatic logic [15:0] pdf_of(input logic [15:0] az);
        logic [47:0] p;
        p = {32'd0, az} * {16'd0, INV_PI_Q32_X2} + 48'h0000_8000_0000;
        return p[47:32];
    endfunction

endpackage
`default_nettype wire

[rtl/core/onb_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module onb_div (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [onb_pkg::NUMER_W-1:0]  numer,
    input  wire logic [15:0]                  divisor,
    output logic [onb_pkg::DIV_STEPS-1:0]     quot,
    output logic                              ovf
);
    import onb_pkg::*;

    localparam int HI_W = NUMER_W - DIV_STEPS;

    logic [15:0]          rem_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] low_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [0:DIV_STEPS];
    logic [15:0]          d_reg   [0:DIV_STEPS];
    logic [DIV_STEPS:0]   ovf_reg;

    // quotient does not fit when the top bits already reach the divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= 16'(numer[NUMER_W-1:DIV_STEPS]);
            low_reg[0] <= numer[DIV_STEPS-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= divisor;
            ovf_reg[0] <= (16'(numer[NUMER_W-1:DIV_STEPS]) >= divisor);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [16:0] trial;
        logic        fits;
        assign trial = {rem_reg[k], low_reg[k][DIV_STEPS-1]};
        assign fits  = (trial >= {1'b0, d_reg[k]});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= fits ? 16'(trial - {1'b0, d_reg[k]}) : trial[15:0];
                low_reg[k+1] <= {low_reg[k][DIV_STEPS-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][DIV_STEPS-2:0], fits};
                d_reg[k+1]   <= d_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quot = q_reg[DIV_STEPS];
    assign ovf  = ovf_reg[DIV_STEPS];

endmodule
`default_nettype wire

[rtl/core/oren_nayar_brdf_eval_top.sv]
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The depth is set by the 35-stage divider, one quotient bit per stage.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// register defaults: A = 1.0, B = 0, every albedo = 65535.
`default_nettype none
module oren_nayar_brdf_eval_top #(
    parameter int NUM_CHANNELS = onb_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // out_x, out_y, out_z, in_x, in_y, in_z
    input  wire logic [onb_pkg::IN_W-1:0]         s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // value_0 .. value_(NUM_CHANNELS-1), forward_pdf, reverse_pdf
    output logic [(NUM_CHANNELS+2)*16-1:0]        m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [onb_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [onb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import onb_pkg::*;

    logic en;

    // configuration
    logic [15:0] coeff_a_reg, coeff_b_reg;
    logic [15:0] albedo_reg [NUM_CHANNELS];
    logic [31:0] ab_reg [NUM_CHANNELS];
    logic [31:0] aa_reg [NUM_CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_a_reg <= COEFF_A_RST;
            coeff_b_reg <= COEFF_B_RST;
            for (int c = 0; c < NUM_CHANNELS; c++) albedo_reg[c] <= ALBEDO_RST;
        end else if (cfg_we) begin
            if (cfg_addr == REG_COEFF_A) coeff_a_reg <= cfg_wdata;
            if (cfg_addr == REG_COEFF_B) coeff_b_reg <= cfg_wdata;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (cfg_addr == CFG_IDX_W'(REG_ALBEDO_0 + c)) albedo_reg[c] <= cfg_wdata;
            end
        end
    end

    // per-channel coefficient products, refreshed every cycle
    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            ab_reg[c] <= {16'd0, albedo_reg[c]} * {16'd0, coeff_b_reg};
            aa_reg[c] <= {16'd0, albedo_reg[c]} * {16'd0, coeff_a_reg};
        end
    end

    // stage 1: products of the tangent components, hemisphere test
    logic signed [15:0] ox, oy, oz, ix, iy, iz;
    assign ox = s_tdata[15:0];
    assign oy = s_tdata[31:16];
    assign oz = s_tdata[47:32];
    assign ix = s_tdata[63:48];
    assign iy = s_tdata[79:64];
    assign iz = s_tdata[95:80];

    logic               v1_reg, same1_reg, full1_reg;
    logic signed [31:0] px1_reg, py1_reg;
    logic [15:0]        aiz1_reg, aoz1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg   <= ix * ox;
            py1_reg   <= iy * oy;
            aiz1_reg  <= iz[15] ? 16'(-iz) : 16'(iz);
            aoz1_reg  <= oz[15] ? 16'(-oz) : 16'(oz);
            same1_reg <= (!oz[15] && oz != 16'sd0 && !iz[15] && iz != 16'sd0) ||
                         (oz[15] && iz[15]);
            full1_reg <= (iz == 16'sh8000) || (oz == 16'sh8000);
        end
    end

    // stage 2: dot product, larger |z|, pdfs
    logic signed [32:0] dot;
    assign dot = 33'(px1_reg) + 33'(py1_reg);

    logic        v2_reg, same2_reg;
    logic [31:0] pos2_reg;
    logic [15:0] mz2_reg, pf2_reg, pr2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos2_reg  <= (dot > 33'sd0 && !full1_reg) ? dot[31:0] : 32'd0;
            mz2_reg   <= (aiz1_reg > aoz1_reg) ? aiz1_reg : aoz1_reg;
            pf2_reg   <= pdf_of(aiz1_reg);
            pr2_reg   <= pdf_of(aoz1_reg);
            same2_reg <= same1_reg;
        end
    end

    // stage 3: albedo * B * dot
    logic        v3_reg, same3_reg;
    logic [63:0] prod3_reg [NUM_CHANNELS];
    logic [15:0] mz3_reg, pf3_reg, pr3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                prod3_reg[c] <= {32'd0, ab_reg[c]} * {32'd0, pos2_reg};
            end
            mz3_reg   <= mz2_reg;
            pf3_reg   <= pf2_reg;
            pr3_reg   <= pr2_reg;
            same3_reg <= same2_reg;
        end
    end

    // divider: floor(prod / 2^15 / mz) per channel
    logic [DIV_STEPS-1:0] quot [NUM_CHANNELS];
    logic                 ovf  [NUM_CHANNELS];

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_div
        onb_div u_div (
            .aclk    (aclk),
            .en      (en),
            .numer   (prod3_reg[c][NUMER_W+14:15]),
            .divisor (mz3_reg),
            .quot    (quot[c]),
            .ovf     (ovf[c])
        );
    end

    // side data travels beside the divider stages
    logic [DIV_STEPS:0] vd_reg;
    logic [DIV_STEPS:0] samed_reg;
    logic [15:0]        pfd_reg [0:DIV_STEPS];
    logic [15:0]        prd_reg [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= '0;
        else if (en)  vd_reg <= {vd_reg[DIV_STEPS-1:0], v3_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            samed_reg  <= {samed_reg[DIV_STEPS-1:0], same3_reg};
            pfd_reg[0] <= pf3_reg;
            prd_reg[0] <= pr3_reg;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                pfd_reg[k] <= pfd_reg[k-1];
                prd_reg[k] <= prd_reg[k-1];
            end
        end
    end

    // stage W: (albedo*A + quotient) * 2^16/pi
    logic            vw_reg, samew_reg;
    logic [WM_W-1:0] wm_reg  [NUM_CHANNELS];
    logic            ovfw_reg [NUM_CHANNELS];
    logic [15:0]     pfw_reg, prw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vw_reg <= 1'b0;
        else if (en)  vw_reg <= vd_reg[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                wm_reg[c]   <= WM_W'(W_W'(aa_reg[c]) + W_W'(quot[c])) *
                               WM_W'(INV_PI_Q16);
                ovfw_reg[c] <= ovf[c];
            end
            samew_reg <= samed_reg[DIV_STEPS];
            pfw_reg   <= pfd_reg[DIV_STEPS];
            prw_reg   <= prd_reg[DIV_STEPS];
        end
    end

    // output stage: round, saturate, zero for opposite hemispheres
    logic        m_tvalid_reg;
    logic [15:0] val_reg [NUM_CHANNELS];
    logic [15:0] pf_out_reg, pr_out_reg;
    logic [WM_W-1:0] rounded [NUM_CHANNELS];
    logic [15:0]     val_next [NUM_CHANNELS];

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            rounded[c] = wm_reg[c] + WM_W'(33'h0_8000_0000);
            if (!samew_reg)
                val_next[c] = 16'd0;
            else if (ovfw_reg[c] || rounded[c][WM_W-1:48] != '0)
                val_next[c] = 16'hFFFF;
            else
                val_next[c] = rounded[c][47:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (en)  m_tvalid_reg <= vw_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CHANNELS; c++) val_reg[c] <= val_next[c];
            pf_out_reg <= samew_reg ? pfw_reg : 16'd0;
            pr_out_reg <= samew_reg ? prw_reg : 16'd0;
        end
    end

    // advance whenever the output register is empty or being drained
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) m_tdata[c*16 +: 16] = val_reg[c];
        m_tdata[NUM_CHANNELS*16 +: 16]     = pf_out_reg;
        m_tdata[(NUM_CHANNELS+1)*16 +: 16] = pr_out_reg;
    end

endmodule
`default_nettype wire

[rtl/core/onb_check.sv]
// Port-level checker for the Oren-Nayar evaluator, bound to the top level.
`default_nettype none
module onb_check #(
    parameter int NUM_CHANNELS = onb_pkg::NUM_CHANNELS_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [(NUM_CHANNELS+2)*16-1:0] m_tdata
);
    import onb_pkg::*;

    logic [15:0] fwd, rev;
    assign fwd = m_tdata[NUM_CHANNELS*16 +: 16];
    assign rev = m_tdata[(NUM_CHANNELS+1)*16 +: 16];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && fwd == 16'd0 |-> m_tdata == '0)
        else $error("opposite-hemisphere item has nonzero fields");

    a_pdf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> fwd <= 16'd20861 && rev <= 16'd20861)
        else $error("pdf above 1/pi");

endmodule

bind oren_nayar_brdf_eval_top onb_check #(.NUM_CHANNELS(NUM_CHANNELS)) u_onb_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
